// ----- rtl/rdc_pkg.sv -----
// Package: shared types, constants and helpers for the radix digit converter.
`timescale 1ns / 1ps
package rdc_pkg;

  localparam int VALUE_BITS_DEF = 31;
  localparam int RADIX_BITS     = 5;
  localparam int DIGIT_BITS     = 4;
  localparam int CHAR_BITS      = 7;
  localparam logic [RADIX_BITS-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX = 5'd16;
  localparam logic [CHAR_BITS-1:0]  CHAR_ZERO = 7'h30;
  localparam logic [CHAR_BITS-1:0]  CHAR_A    = 7'h41;
  localparam logic [DIGIT_BITS-1:0] DEC_LIMIT = 4'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT,
    ST_ERR
  } state_t;

  // Per-cycle command broadcast along the cell row
  typedef struct packed {
    logic clear;
    logic conv;
    logic shift;
  } cell_ctl_t;

  function automatic logic [CHAR_BITS-1:0] to_ascii(input logic [DIGIT_BITS-1:0] d);
    logic [CHAR_BITS-1:0] c;
    if (d < DEC_LIMIT) begin
      c = CHAR_ZERO + CHAR_BITS'(d);
    end else begin
      c = CHAR_A + CHAR_BITS'(d - DEC_LIMIT);
    end
    return c;
  endfunction

endpackage

// ----- rtl/rdc_if.sv -----
// Interfaces: input and result channels with valid/ready handshake.
`timescale 1ns / 1ps
interface rdc_in_if #(parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF);
  logic                              valid;
  logic                              ready;
  logic [VALUE_BITS-1:0]             value;
  logic [rdc_pkg::RADIX_BITS-1:0]    radix;
  modport source (output valid, value, radix, input ready);
  modport sink   (input valid, value, radix, output ready);
endinterface

interface rdc_out_if;
  logic                              valid;
  logic                              ready;
  logic [rdc_pkg::CHAR_BITS-1:0]     digit_char;
  logic                              last;
  logic                              status;
  modport source (output valid, digit_char, last, status, input ready);
  modport sink   (input valid, digit_char, last, status, output ready);
endinterface

// ----- rtl/rdc_cell.sv -----
// One digit cell: clears, doubles its digit and adds the carry modulo radix, or shifts.
`timescale 1ns / 1ps
module rdc_cell (
  input  logic                               clk,
  input  rdc_pkg::cell_ctl_t                 ctl,
  input  logic [rdc_pkg::RADIX_BITS-1:0]     radix,
  input  logic                               carry_in,
  input  logic                               valid_in,
  input  logic [rdc_pkg::DIGIT_BITS-1:0]     shift_in,
  output logic [rdc_pkg::DIGIT_BITS-1:0]     digit,
  output logic                               carry_out,
  output logic                               valid_out
);
  import rdc_pkg::*;

  logic [RADIX_BITS-1:0] dbl;
  logic [RADIX_BITS-1:0] dbl_red;
  logic                  wrap;

  // 2*d + c, reduced once (result < 2*radix)
  assign dbl     = {digit, carry_in};
  assign wrap    = (dbl >= radix);
  assign dbl_red = wrap ? (dbl - radix) : dbl;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digit     <= '0;
      valid_out <= 1'b0;
      carry_out <= 1'b0;
    end else if (ctl.conv) begin
      valid_out <= valid_in;
      carry_out <= valid_in & wrap;
      if (valid_in) begin
        digit <= dbl_red[DIGIT_BITS-1:0];
      end
    end else if (ctl.shift) begin
      digit     <= shift_in;
      valid_out <= 1'b0;
    end
  end
endmodule

// ----- rtl/radix_digit_converter_unit.sv -----
// Top level: converts a number to ASCII digits in base 2..16, MSB digit first.
// Each item feeds its bits MSB first into a row of VALUE_BITS digit cells,
// lets the carries ripple through the registered cell row, then shifts the
// digits out of the top cell (leading zeros are dropped without a beat, so
// the result count is the digit count). One item is in work at a time, and
// output stalls hold the shifting; an unsupported base gives one error beat.
`timescale 1ns / 1ps
module radix_digit_converter_unit #(
  parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  rdc_in_if.sink    req,
  rdc_out_if.source rsp
);
  import rdc_pkg::*;

  localparam int NDIG = VALUE_BITS;
  localparam int CW   = $clog2(VALUE_BITS + NDIG);
  localparam int ECW  = $clog2(NDIG);

  state_t                 state, state_next;
  logic [VALUE_BITS-1:0]  value_sh;
  logic [RADIX_BITS-1:0]  radix_r;
  logic [CW-1:0]          cyc;
  logic [ECW-1:0]         ecnt;
  logic                   started;

  cell_ctl_t              ctl;
  logic [DIGIT_BITS-1:0]  dig   [NDIG];
  logic                   carry [NDIG];
  logic                   vld   [NDIG];

  logic accept, bad_radix, conv_done, show, emit_last, advance;

  assign accept    = req.valid & req.ready;
  assign bad_radix = (req.radix < RADIX_MIN) || (req.radix > RADIX_MAX);
  assign conv_done = (cyc == CW'(VALUE_BITS + NDIG - 2));
  assign emit_last = (ecnt == ECW'(NDIG - 1));
  assign show      = started | (dig[NDIG-1] != '0) | emit_last;
  assign advance   = (state == ST_EMIT) & (~show | rsp.ready);

  // Cell row
  generate
    for (genvar k = 0; k < NDIG; k++) begin : g_cell
      if (k == 0) begin : g_first
        rdc_cell u_cell (
          .clk(clk), .ctl(ctl), .radix(radix_r),
          .carry_in(value_sh[VALUE_BITS-1]),
          .valid_in(cyc < CW'(VALUE_BITS)),
          .shift_in('0),
          .digit(dig[k]), .carry_out(carry[k]), .valid_out(vld[k])
        );
      end else begin : g_rest
        rdc_cell u_cell (
          .clk(clk), .ctl(ctl), .radix(radix_r),
          .carry_in(carry[k-1]), .valid_in(vld[k-1]), .shift_in(dig[k-1]),
          .digit(dig[k]), .carry_out(carry[k]), .valid_out(vld[k])
        );
      end
    end
  endgenerate

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = bad_radix ? ST_ERR : ST_CONV;
      ST_CONV: if (conv_done) state_next = ST_EMIT;
      ST_EMIT: if (advance && emit_last) state_next = ST_IDLE;
      ST_ERR:  if (rsp.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    req.ready      = 1'b0;
    rsp.valid      = 1'b0;
    rsp.digit_char = '0;
    rsp.last       = 1'b0;
    rsp.status     = 1'b0;
    ctl            = '0;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        ctl.clear = accept;
      end
      ST_CONV: ctl.conv = 1'b1;
      ST_EMIT: begin
        rsp.valid      = show;
        rsp.digit_char = to_ascii(dig[NDIG-1]);
        rsp.last       = emit_last;
        ctl.shift      = advance;
      end
      ST_ERR: begin
        rsp.valid  = 1'b1;
        rsp.last   = 1'b1;
        rsp.status = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cyc     <= '0;
      ecnt    <= '0;
      started <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        cyc     <= '0;
        ecnt    <= '0;
        started <= 1'b0;
      end else begin
        if (state == ST_CONV) cyc <= cyc + 1'b1;
        if (advance) begin
          ecnt    <= ecnt + 1'b1;
          started <= started | show;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      value_sh <= req.value;
      radix_r  <= req.radix;
    end else if (state == ST_CONV) begin
      value_sh <= {value_sh[VALUE_BITS-2:0], 1'b0};
    end
  end

  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status |-> rsp.last && (rsp.digit_char == '0))
    else $error("error beat malformed");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("accepted while busy");
  a_no_out_conv: assert property (@(posedge clk) disable iff (rst)
    state == ST_CONV |-> !rsp.valid)
    else $error("beat during conversion");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.ready && rsp.last |=> state == ST_IDLE)
    else $error("run did not end on last beat");
endmodule
